[rtl/erq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants of the echo range qualifier
package erq_pkg;

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 32;
  localparam int US_W       = 8;
  localparam int MS_W       = 16;
  localparam int CHG_W      = 8;
  localparam int DEAD_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_US_PER_CM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_INTVL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_TMO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_LIMIT  = 3'd4;

  // register values after reset
  localparam logic [US_W-1:0]   US_PER_CM_RST  = 8'd57;
  localparam logic [MS_W-1:0]   PING_INTVL_RST = 16'd100;
  localparam logic [MS_W-1:0]   PING_TMO_RST   = 16'd50;
  localparam logic [CHG_W-1:0]  MIN_CHANGE_RST = 8'd5;
  localparam logic [DEAD_W-1:0] DEAD_LIMIT_RST = 5'd16;

  // request kinds
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_ECHO = 1'b1;

  // echoes must exceed this many centimetres
  localparam logic [1:0] MIN_ECHO_CM = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_CM,
    ST_ECHO,
    ST_EMIT
  } erq_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic save_mean;
    logic start_cm;
    logic tick_upd;
    logic echo_upd;
    logic emit;
  } erq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic is_echo;
    logic out_free;
  } erq_stat_t;

endpackage
`default_nettype wire

[rtl/erq_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// request and result channel interfaces of the echo range qualifier

// request channel: tick or echo
interface erq_in_if;
  import erq_pkg::*;
  logic                valid;
  logic                ready;
  logic                func;
  logic [TIME_W-1:0]   now_ms;
  logic [SAMPLE_W-1:0] echo_us;

  modport source (output valid, output func, output now_ms, output echo_us, input ready);
  modport sink   (input valid, input func, input now_ms, input echo_us, output ready);
endinterface

// result channel
interface erq_out_if;
  import erq_pkg::*;
  logic                valid;
  logic                ready;
  logic                start_ping;
  logic [SAMPLE_W-1:0] distance_cm;
  logic                changed;
  logic                dead;
  logic                echo_accepted;

  modport source (output valid, output start_ping, output distance_cm, output changed,
                  output dead, output echo_accepted, input ready);
  modport sink   (input valid, input start_ping, input distance_cm, input changed,
                  input dead, input echo_accepted, output ready);
endinterface
`default_nettype wire

[rtl/erq_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module erq_div #(
  parameter int DW  = 19,
  parameter int VW  = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               busy_o,
  output logic [DW-1:0]      quo_o
);
  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;

  // one shift and subtract step
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
    rem_d   = ge ? diff[VW-1:0] : shifted[VW-1:0];
    quo_d   = {quo_q[DW-2:0], ge};
    cnt_d   = cnt_q - CW'(1);
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(DW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_d;
    end
  end

  // remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

[rtl/erq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// sequencing state machine of the echo range qualifier
module erq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire erq_pkg::erq_stat_t stat_i,
  output erq_pkg::erq_cmd_t       cmd_o
);
  import erq_pkg::*;

  erq_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MEAN;
      end
      ST_MEAN: begin
        if (!stat_i.div_busy) state_d = stat_i.is_echo ? ST_ECHO : ST_CM;
      end
      ST_CM: begin
        if (!stat_i.div_busy) state_d = ST_EMIT;
      end
      ST_ECHO: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MEAN: begin
        cmd_o.save_mean = !stat_i.div_busy;
        cmd_o.start_cm  = !stat_i.div_busy && !stat_i.is_echo;
      end
      ST_CM: begin
        cmd_o.tick_upd = !stat_i.div_busy;
      end
      ST_ECHO: begin
        cmd_o.echo_upd = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end
endmodule
`default_nettype wire

[rtl/erq_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// datapath: configuration, window, ping state, divider and result register
module erq_dp #(
  parameter int WINDOW = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [erq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [erq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            func_i,
  input  wire logic [erq_pkg::TIME_W-1:0]      now_ms_i,
  input  wire logic [erq_pkg::SAMPLE_W-1:0]    echo_us_i,
  input  wire erq_pkg::erq_cmd_t               cmd_i,
  output erq_pkg::erq_stat_t                   stat_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 start_ping_o,
  output logic [erq_pkg::SAMPLE_W-1:0]         distance_cm_o,
  output logic                                 changed_o,
  output logic                                 dead_o,
  output logic                                 echo_accepted_o
);
  import erq_pkg::*;

  localparam int CNTW = $clog2(WINDOW + 1);
  localparam int SLW  = $clog2(WINDOW);
  localparam int SUMW = SAMPLE_W + $clog2(WINDOW);
  localparam int DVW  = (CNTW > US_W) ? CNTW : US_W;
  localparam int LOWW = US_W + 2;
  localparam logic [CNTW-1:0] WIN_FULL = CNTW'(WINDOW);
  localparam logic [SLW-1:0]  SLOT_LAST = SLW'(WINDOW - 1);

  // configuration registers
  logic [US_W-1:0]   us_per_cm_q;
  logic [MS_W-1:0]   intvl_q;
  logic [MS_W-1:0]   tmo_q;
  logic [CHG_W-1:0]  min_change_q;
  logic [DEAD_W-1:0] dead_limit_q;

  // latched request and thresholds
  logic                func_q;
  logic [TIME_W-1:0]   now_q;
  logic [SAMPLE_W-1:0] echo_q;
  logic [LOWW-1:0]     thr_low_q;
  logic [SAMPLE_W-1:0] thr_near_q;
  logic [SAMPLE_W-1:0] mean_q;

  // block state
  logic [SAMPLE_W-1:0] win_mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_q;
  logic [SLW-1:0]      slot_q, slot_d;
  logic [CNTW-1:0]     count_q, count_d;
  logic [SUMW-1:0]     sum_q, sum_d;
  logic                pending_q, pending_d;
  logic [TIME_W-1:0]   start_ms_q, start_ms_d;
  logic [DEAD_W-1:0]   timeout_q, timeout_d;
  logic [SAMPLE_W-1:0] last_q, last_d;

  // result holding and output registers
  logic                res_start_q, res_start_d;
  logic [SAMPLE_W-1:0] res_dist_q, res_dist_d;
  logic                res_chg_q, res_chg_d;
  logic                res_dead_q, res_dead_d;
  logic                res_acc_q, res_acc_d;
  logic                out_valid_q;

  // divider hookup
  logic                div_start;
  logic [SUMW-1:0]     div_dividend;
  logic [DVW-1:0]      div_divisor;
  logic                div_busy;
  logic [SUMW-1:0]     div_quo;
  logic [SAMPLE_W-1:0] mean_c;
  logic [US_W-1:0]     cm_div;

  // tick and echo evaluation
  logic [TIME_W-1:0]   elapsed;
  logic                timed_out;
  logic [DEAD_W-1:0]   timeout_tick;
  logic                dead_tick;
  logic [SAMPLE_W-1:0] dist_tick;
  logic [SAMPLE_W-1:0] dev;
  logic                win_full;
  logic                echo_ok;
  logic [DEAD_W-1:0]   timeout_echo;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      us_per_cm_q  <= US_PER_CM_RST;
      intvl_q      <= PING_INTVL_RST;
      tmo_q        <= PING_TMO_RST;
      min_change_q <= MIN_CHANGE_RST;
      dead_limit_q <= DEAD_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_US_PER_CM:  us_per_cm_q  <= cfg_data_i[US_W-1:0];
        CFG_PING_INTVL: intvl_q      <= cfg_data_i[MS_W-1:0];
        CFG_PING_TMO:   tmo_q        <= cfg_data_i[MS_W-1:0];
        CFG_MIN_CHANGE: min_change_q <= cfg_data_i[CHG_W-1:0];
        CFG_DEAD_LIMIT: dead_limit_q <= cfg_data_i[DEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // divider operand select: window mean first, then centimetre conversion
  assign mean_c       = (count_q == '0) ? '0 : div_quo[SAMPLE_W-1:0];
  assign cm_div       = (us_per_cm_q == '0) ? US_W'(1) : us_per_cm_q;
  assign div_start    = cmd_i.load || cmd_i.start_cm;
  assign div_dividend = cmd_i.start_cm ? SUMW'(mean_c) : sum_q;
  assign div_divisor  = cmd_i.start_cm ? DVW'(cm_div) : DVW'(count_q);

  erq_div #(
    .DW (SUMW),
    .VW (DVW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quo_o      (div_quo)
  );

  // request latch, thresholds and mean
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q     <= func_i;
      now_q      <= now_ms_i;
      echo_q     <= echo_us_i;
      thr_low_q  <= LOWW'(MIN_ECHO_CM) * LOWW'(us_per_cm_q);
      thr_near_q <= SAMPLE_W'(min_change_q) * SAMPLE_W'(us_per_cm_q);
    end
    if (cmd_i.save_mean) begin
      mean_q <= mean_c;
    end
  end

  // tick evaluation
  always_comb begin
    elapsed      = now_q - start_ms_q;
    timed_out    = pending_q && (elapsed > TIME_W'(tmo_q));
    timeout_tick = (timed_out && (timeout_q < dead_limit_q)) ? timeout_q + DEAD_W'(1)
                                                              : timeout_q;
    dead_tick    = (timeout_tick >= dead_limit_q);
    dist_tick    = dead_tick ? '0 : div_quo[SAMPLE_W-1:0];
  end

  // echo evaluation
  always_comb begin
    dev          = (mean_q > echo_q) ? mean_q - echo_q : echo_q - mean_q;
    win_full     = (count_q == WIN_FULL);
    echo_ok      = pending_q && (echo_q > SAMPLE_W'(thr_low_q)) &&
                   (!win_full || (dev <= thr_near_q));
    timeout_echo = echo_ok ? '0 : timeout_q;
  end

  // next state and result
  always_comb begin
    slot_d      = slot_q;
    count_d     = count_q;
    sum_d       = sum_q;
    pending_d   = pending_q;
    start_ms_d  = start_ms_q;
    timeout_d   = timeout_q;
    last_d      = last_q;
    res_start_d = res_start_q;
    res_dist_d  = res_dist_q;
    res_chg_d   = res_chg_q;
    res_dead_d  = res_dead_q;
    res_acc_d   = res_acc_q;
    if (cmd_i.tick_upd) begin
      res_start_d = 1'b0;
      if (!pending_q || timed_out) begin
        if (elapsed > TIME_W'(intvl_q)) begin
          res_start_d = 1'b1;
          pending_d   = 1'b1;
          start_ms_d  = now_q;
        end else if (timed_out) begin
          pending_d = 1'b0;
        end
      end
      timeout_d  = timeout_tick;
      res_dist_d = dist_tick;
      res_chg_d  = (dist_tick != last_q);
      res_dead_d = dead_tick;
      res_acc_d  = 1'b0;
      last_d     = dist_tick;
    end
    if (cmd_i.echo_upd) begin
      pending_d   = 1'b0;
      timeout_d   = timeout_echo;
      res_start_d = 1'b0;
      res_dist_d  = '0;
      res_chg_d   = 1'b0;
      res_dead_d  = (timeout_echo >= dead_limit_q);
      res_acc_d   = echo_ok;
      if (echo_ok) begin
        count_d = win_full ? count_q : count_q + CNTW'(1);
        sum_d   = (win_full ? sum_q - SUMW'(rd_q) : sum_q) + SUMW'(echo_q);
        slot_d  = (slot_q == SLOT_LAST) ? '0 : slot_q + SLW'(1);
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      count_q    <= '0;
      sum_q      <= '0;
      pending_q  <= 1'b0;
      start_ms_q <= '0;
      timeout_q  <= '0;
      last_q     <= '0;
    end else begin
      slot_q     <= slot_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      pending_q  <= pending_d;
      start_ms_q <= start_ms_d;
      timeout_q  <= timeout_d;
      last_q     <= last_d;
    end
  end

  // sample window memory, read at the slot about to be overwritten
  always_ff @(posedge clk_i) begin
    if (cmd_i.echo_upd && echo_ok) begin
      win_mem[slot_q] <= echo_q;
    end
    rd_q <= win_mem[slot_q];
  end

  // result holding register
  always_ff @(posedge clk_i) begin
    res_start_q <= res_start_d;
    res_dist_q  <= res_dist_d;
    res_chg_q   <= res_chg_d;
    res_dead_q  <= res_dead_d;
    res_acc_q   <= res_acc_d;
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      start_ping_o    <= res_start_q;
      distance_cm_o   <= res_dist_q;
      changed_o       <= res_chg_q;
      dead_o          <= res_dead_q;
      echo_accepted_o <= res_acc_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.div_busy = div_busy;
  assign stat_o.is_echo  = (func_q == FUNC_ECHO);
  assign stat_o.out_free = !out_valid_q || out_ready_i;
endmodule
`default_nettype wire

[rtl/echo_range_qualifier.sv]
`timescale 1ns / 1ps
`default_nettype none
// top level of the echo range qualifier
//
// usage:
// - req_i carries one request per handshake: a tick (func 0) with the current
//   millisecond time, or an echo (func 1) with a round-trip time in microseconds
// - rsp_o returns exactly one result per request, in request order
// - configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the
//   user must write it only while the block is idle (not enforced by the block);
//   indexes 0..4: us_per_cm, ping interval, ping timeout, min change, dead limit
// - one request is worked on at a time; it shares the one-bit-per-cycle divider
//   between its divisions, which produce SUMW = 16 + clog2(WINDOW) quotient bits
// - a tick runs two divisions (window mean, then centimetres); an echo runs
//   one, the window mean
// - results sit in an output register; a new request is taken while a result
//   waits, and the block stalls only when the next result is ready before the
//   receiver has taken the previous one
// - reset clears window fill, ping state, timeout count and last report, and
//   loads the register defaults; no clearing pass is needed
module echo_range_qualifier #(
  parameter int WINDOW = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  erq_in_if.sink                              req_i,
  erq_out_if.source                           rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [erq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [erq_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import erq_pkg::*;

  erq_cmd_t  cmd;
  erq_stat_t stat;
  logic      in_ready;

  // sequencer
  erq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  assign req_i.ready = in_ready;

  // datapath
  erq_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (req_i.func),
    .now_ms_i        (req_i.now_ms),
    .echo_us_i       (req_i.echo_us),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .start_ping_o    (rsp_o.start_ping),
    .distance_cm_o   (rsp_o.distance_cm),
    .changed_o       (rsp_o.changed),
    .dead_o          (rsp_o.dead),
    .echo_accepted_o (rsp_o.echo_accepted)
  );
endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench of the echo range qualifier: scheduled ping, echo and timeout traffic
module tb_top;
  import erq_pkg::*;

  localparam int WIN    = 8;
  localparam int SETTLE = 60;

  // receiver stall modes
  localparam int RDY_ALWAYS = 0;
  localparam int RDY_HALF   = 1;
  localparam int RDY_SPARSE = 2;

  typedef struct packed {
    logic                func;
    logic [TIME_W-1:0]   now_ms;
    logic [SAMPLE_W-1:0] echo_us;
  } echo_req_t;

  typedef struct packed {
    logic                start_ping;
    logic [SAMPLE_W-1:0] distance_cm;
    logic                changed;
    logic                dead;
    logic                echo_accepted;
  } range_rsp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  erq_in_if  req_if ();
  erq_out_if rsp_if ();

  echo_range_qualifier #(.WINDOW(WIN)) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_o     (rsp_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // register shadows
  logic [US_W-1:0]   r_us_cm;
  logic [MS_W-1:0]   r_intvl;
  logic [MS_W-1:0]   r_tmo;
  logic [CHG_W-1:0]  r_max_dev;
  logic [DEAD_W-1:0] r_dead_lim;

  // predicted block state
  logic [SAMPLE_W-1:0] win_mem [WIN];
  logic [2:0]          win_wr;
  logic [3:0]          win_cnt;
  logic [18:0]         win_sum;
  logic                pinging;
  logic [TIME_W-1:0]   ping_t0;
  logic [DEAD_W-1:0]   miss_cnt;
  logic [SAMPLE_W-1:0] prev_cm;

  echo_req_t  req_q [$];
  range_rsp_t exp_rsp_q [$];
  int         made_cnt;
  int         rsp_cnt;
  int         fail_cnt;

  // expected result of one request, advances the predicted state
  function automatic range_rsp_t qualify_request(echo_req_t rq);
    range_rsp_t  rs;
    logic [31:0] elapsed;
    logic        timed_out;
    int unsigned div, mean, dev, cm, echo;
    rs   = '0;
    echo = rq.echo_us;
    mean = (win_cnt == 0) ? 0 : win_sum / win_cnt;
    if (rq.func == FUNC_TICK) begin
      elapsed   = rq.now_ms - ping_t0;
      timed_out = pinging && (elapsed > r_tmo);
      div       = (r_us_cm == 0) ? 1 : r_us_cm;
      if (!pinging || timed_out) begin
        if (elapsed > r_intvl) begin
          rs.start_ping = 1'b1;
          pinging       = 1'b1;
          ping_t0       = rq.now_ms;
        end else if (timed_out) begin
          pinging = 1'b0;
        end
      end
      cm = (mean / div) & 32'hFFFF;
      if (timed_out && miss_cnt < r_dead_lim) miss_cnt++;
      if (miss_cnt >= r_dead_lim) cm = 0;
      rs.distance_cm = cm[15:0];
      rs.changed     = (cm[15:0] != prev_cm);
      prev_cm        = cm[15:0];
    end else if (pinging) begin
      dev = (mean > echo) ? mean - echo : echo - mean;
      if (echo > 3 * int'(r_us_cm) &&
          (win_cnt < WIN || dev <= int'(r_max_dev) * int'(r_us_cm))) begin
        if (win_cnt >= WIN) win_sum -= win_mem[win_wr];
        else win_cnt++;
        win_mem[win_wr] = rq.echo_us;
        win_sum += rq.echo_us;
        win_wr++;
        miss_cnt         = '0;
        rs.echo_accepted = 1'b1;
      end
      pinging = 1'b0;
    end
    rs.dead = (miss_cnt >= r_dead_lim);
    return rs;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // request driver: bursts with random gaps
  int burst_left = 1;
  int gap_left   = 0;
  echo_req_t cur_req;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      if (req_if.valid && req_if.ready) exp_rsp_q.push_back(qualify_request(cur_req));
      if (req_if.valid && !req_if.ready) begin
        // hold the offered request
      end else if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        cur_req = req_q.pop_front();
        req_if.valid   <= 1'b1;
        req_if.func    <= cur_req.func;
        req_if.now_ms  <= cur_req.now_ms;
        req_if.echo_us <= cur_req.echo_us;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(40, 1);
          gap_left   = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(30, 1);
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result monitor with its own stall pattern and two long hold-offs
  int rdy_mode  = RDY_ALWAYS;
  int seg_left  = 0;
  int hold_left = 0;
  range_rsp_t want_rsp;
  logic rdy;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_cnt++;
        if (rsp_cnt == 400 || rsp_cnt == 1400) hold_left = 300;
        if (exp_rsp_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt++;
        end else begin
          want_rsp = exp_rsp_q.pop_front();
          check_field("start_ping", want_rsp.start_ping, rsp_if.start_ping);
          check_field("distance_cm", want_rsp.distance_cm, rsp_if.distance_cm);
          check_field("changed", want_rsp.changed, rsp_if.changed);
          check_field("dead", want_rsp.dead, rsp_if.dead);
          check_field("echo_accepted", want_rsp.echo_accepted, rsp_if.echo_accepted);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (seg_left == 0) begin
          rdy_mode = $urandom_range(RDY_SPARSE, RDY_ALWAYS);
          seg_left = $urandom_range(150, 10);
        end else begin
          seg_left--;
        end
        case (rdy_mode)
          RDY_ALWAYS: rdy = 1'b1;
          RDY_HALF:   rdy = 1'($urandom_range(1, 0));
          default:    rdy = ($urandom_range(3, 0) == 0);
        endcase
      end
      rsp_if.ready <= rdy;
    end
  end

  task automatic add_tick(logic [31:0] t);
    echo_req_t rq;
    rq.func    = FUNC_TICK;
    rq.now_ms  = t;
    rq.echo_us = 16'($urandom());
    req_q.push_back(rq);
    made_cnt++;
  endtask

  task automatic add_echo(logic [15:0] us);
    echo_req_t rq;
    rq.func    = FUNC_ECHO;
    rq.now_ms  = $urandom();
    rq.echo_us = us;
    req_q.push_back(rq);
    made_cnt++;
  endtask

  function automatic int unsigned near_value(int unsigned center, int unsigned spread,
                                             int unsigned floor_v);
    int unsigned lo, hi;
    lo = (center > spread + floor_v) ? center - spread : floor_v;
    hi = (center + spread > 65535) ? 65535 : center + spread;
    if (lo > hi) lo = hi;
    return $urandom_range(hi, lo);
  endfunction

  // mostly ping/echo sequences, with boundary ticks, silent stretches and noise
  task automatic gen_random(int n, int unsigned ms_start);
    int unsigned ms, ping_ms, base, spread, us_eff, floor_v, thr, big;
    int          first, r, k;
    ms      = ms_start;
    ping_ms = ms_start;
    us_eff  = (r_us_cm == 0) ? 1 : r_us_cm;
    floor_v = 3 * us_eff + 1;
    spread  = (int'(r_max_dev) + 2) * us_eff;
    base    = $urandom_range(20000, floor_v);
    big     = ((r_intvl > r_tmo) ? r_intvl : r_tmo) + 1;
    first   = made_cnt;
    while (made_cnt - first < n) begin
      r = $urandom_range(99, 0);
      if (r < 55) begin
        // ping, usually followed by an echo near the running distance
        ms      = ms + r_intvl + $urandom_range(3, 1);
        ping_ms = ms;
        add_tick(ms);
        r = $urandom_range(99, 0);
        if (r < 5) base = $urandom_range(65535, floor_v);
        else base = near_value(base, spread / 2, floor_v);
        if (r < 75) add_echo(16'(near_value(base, spread, 0)));
        else if (r < 85) add_echo(16'($urandom_range(floor_v, 0)));
      end else if (r < 75) begin
        // tick right around the interval or timeout
        thr = ($urandom_range(1, 0) == 0) ? r_intvl : r_tmo;
        ms  = ping_ms + thr + $urandom_range(2, 0) - 1;
        add_tick(ms);
      end else if (r < 83) begin
        // pings with no echo, runs of timeouts
        k = $urandom_range(35, 1);
        repeat (k) begin
          ms      = ms + big + $urandom_range(2, 0);
          ping_ms = ms;
          add_tick(ms);
        end
      end else if (r < 90) begin
        if ($urandom_range(1, 0) == 0) add_tick($urandom());
        else add_echo(16'($urandom()));
      end else begin
        add_echo(($urandom_range(1, 0) == 0) ? 16'(near_value(base, spread, 0))
                                              : 16'($urandom()));
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  task automatic apply_cfg(int unsigned us, int unsigned iv, int unsigned tmo,
                           int unsigned mc, int unsigned dl);
    write_reg(CFG_US_PER_CM, CFG_DATA_W'(us));
    write_reg(CFG_PING_INTVL, CFG_DATA_W'(iv));
    write_reg(CFG_PING_TMO, CFG_DATA_W'(tmo));
    write_reg(CFG_MIN_CHANGE, CFG_DATA_W'(mc));
    write_reg(CFG_DEAD_LIMIT, CFG_DATA_W'(dl));
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    r_us_cm    = US_W'(us);
    r_intvl    = MS_W'(iv);
    r_tmo      = MS_W'(tmo);
    r_max_dev  = CHG_W'(mc);
    r_dead_lim = DEAD_W'(dl);
  endtask

  // wait until every request has been answered and the block is quiet
  task automatic drain();
    while (req_q.size() != 0 || req_if.valid || exp_rsp_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // run limit
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // main sequence
  initial begin
    int i;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    req_if.valid   = 1'b0;
    req_if.func    = FUNC_TICK;
    req_if.now_ms  = '0;
    req_if.echo_us = '0;
    rsp_if.ready   = 1'b0;
    made_cnt       = 0;
    rsp_cnt        = 0;
    fail_cnt       = 0;
    r_us_cm        = US_PER_CM_RST;
    r_intvl        = PING_INTVL_RST;
    r_tmo          = PING_TMO_RST;
    r_max_dev      = MIN_CHANGE_RST;
    r_dead_lim     = DEAD_LIMIT_RST;
    win_wr         = '0;
    win_cnt        = '0;
    win_sum        = '0;
    pinging        = 1'b0;
    ping_t0        = '0;
    miss_cnt       = '0;
    prev_cm        = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset settings
    add_echo(16'd5000);                 // echo with no ping pending
    add_tick(32'd101);                  // first start, just past the interval
    add_echo(16'd171);                  // exactly three centimetres: too close
    add_tick(32'd202);
    add_echo(16'd172);                  // just above three centimetres
    add_tick(32'd303);
    add_echo(16'hFFFF);
    add_tick(32'd404);
    add_tick(32'd455);                  // timeout without a new start
    add_tick(32'hFFFF_FF00);
    add_tick(32'h0000_0010);            // time wraps: timeout and restart
    add_echo(16'd6000);
    for (i = 0; i < 5; i++) begin
      add_tick(32'h10 + 101 * (i + 1));
      add_echo(16'd3000 + 16'(i * 40));
    end
    add_tick(32'hFFFF_FFFF);
    gen_random(240, $urandom());

    for (i = 1; i < 8; i++) begin
      drain();
      case (i)
        1: apply_cfg(1, 1, 1, 0, 1);
        2: apply_cfg(255, 65535, 65535, 255, 31);
        3: apply_cfg(0, 0, 0, 0, 0);
        4: apply_cfg($urandom_range(255, 1), $urandom_range(65535, 1),
                     $urandom_range(65535, 1), $urandom_range(255, 0),
                     $urandom_range(31, 1));
        default: apply_cfg($urandom_range(255, 1), $urandom_range(300, 1),
                           $urandom_range(300, 1), $urandom_range(20, 0),
                           $urandom_range(31, 1));
      endcase
      @(negedge clk_i);
      gen_random(240, (i == 2) ? 32'hFFFF_0000 : $urandom());
    end
    drain();

    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/erq_pkg.sv
rtl/erq_if.sv
rtl/erq_div.sv
rtl/erq_ctrl.sv
rtl/erq_dp.sv
rtl/echo_range_qualifier.sv
dv/tb_top.sv
